FILE: sv/walsh_hadamard_transform_unit_assert.svh
// Assertion macros for the checker of this block.
// Each use sits on a line of its own and reports through $error.
`ifndef WALSH_HADAMARD_TRANSFORM_UNIT_ASSERT_SVH
`define WALSH_HADAMARD_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define WHT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wht assertion failed");

// Next-cycle implication, quiet while reset is asserted.
`define WHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wht assertion failed");

`endif

FILE: sv/wht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wht_pkg
// Shared constants of the Walsh-Hadamard transform unit.
// ----------------------------------------------------------------------------
package wht_pkg;

	localparam int DEF_MAX_LENGTH   = 64;
	localparam int DEF_SAMPLE_WIDTH = 16;

	// log2 length register
	localparam int              CFG_W     = 3;
	localparam logic [CFG_W-1:0] CFG_RESET = 3'd6;

endpackage

FILE: sv/walsh_hadamard_transform_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walsh_hadamard_transform_unit
// Integer fast Walsh-Hadamard transform over 2^log2_length samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, sample): one signed sample per word, in
// vector order. in_ready is high only while the unit is loading.
// Output channel (out_valid/out_ready, coefficient, last_out): the N
// coefficients in natural order, last_out on the final one.
// cfg_we/cfg_wdata write log2_length (capped at log2 of the largest power of
// two not above MAX_LENGTH); write only while the unit is idle.
// Sequence for N = 2^log2_length: N samples are loaded, then log2(N) passes
// of the single butterfly run, each over N/2 pairs (read state, then sum
// write state, the difference written during the next read) and closed by
// a drain state; then a read state and the emit of N coefficients. The
// single write port of the vector store gives each pair a read and a write state.
// Reset: log2_length = 6, load count cleared; store contents undefined.
// A stalled receiver holds the output register and freezes the emit walk;
// after the last word is registered the unit loads again at once.
// ----------------------------------------------------------------------------
module walsh_hadamard_transform_unit
	import wht_pkg::*;
#(
	parameter int  MAX_LENGTH   = DEF_MAX_LENGTH,
	parameter int  SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	localparam int LOG_CAP      = $clog2(MAX_LENGTH + 1) - 1,
	localparam int COEF_W       = SAMPLE_WIDTH + LOG_CAP + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [COEF_W-1:0] coefficient,
	output logic                     last_out
);

	localparam int AW    = LOG_CAP;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD,
		ST_WS,
		ST_WD,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	logic [CFG_W-1:0]          cfg_q;
	logic [AW-1:0]             cnt_q;
	logic [CFG_W-1:0]          len_log_q;
	logic [CFG_W-1:0]          stage_q;
	logic [AW-1:0]             bfly_q;
	logic [AW-1:0]             idx_q;
	logic                      pend_q;
	logic [AW-1:0]             pend_addr_q;
	logic signed [COEF_W-1:0]  diff_q;
	logic                      out_valid_q;
	logic signed [COEF_W-1:0]  coef_q;
	logic                      last_q;

	logic signed [COEF_W-1:0]  store_q [DEPTH];
	logic signed [COEF_W-1:0]  rd_a_q;
	logic signed [COEF_W-1:0]  rd_b_q;

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic signed [COEF_W-1:0]  mem_wdata;
	logic                      mem_re;
	logic [AW-1:0]             mem_ra;
	logic [AW-1:0]             mem_rb;

	logic [CFG_W-1:0]          eff_log;
	logic [AW:0]               len_in;
	logic [AW:0]               load_next;
	logic [AW-1:0]             half;
	logic [AW-1:0]             low_mask;
	logic [AW-1:0]             hi_bits;
	logic [AW-1:0]             addr_a;
	logic [AW-1:0]             addr_b;
	logic [AW:0]               len_m1;
	logic [AW:0]               pairs_m1;
	logic                      bfly_last;
	logic                      emit_last;
	logic                      out_free;

	assign eff_log   = (cfg_q > CFG_W'(LOG_CAP)) ? CFG_W'(LOG_CAP) : cfg_q;
	assign len_in    = (AW+1)'(1) << eff_log;
	assign load_next = {1'b0, cnt_q} + (AW+1)'(1);

	// pair addresses: insert a zero at bit 'stage' of the pair index
	assign half     = AW'(1) << stage_q;
	assign low_mask = half - AW'(1);
	assign hi_bits  = bfly_q & ~low_mask;
	assign addr_a   = (hi_bits << 1) | (bfly_q & low_mask);
	assign addr_b   = addr_a | half;

	assign len_m1    = ((AW+1)'(1) << len_log_q) - (AW+1)'(1);
	assign pairs_m1  = (((AW+1)'(1) << len_log_q) >> 1) - (AW+1)'(1);
	assign bfly_last = ({1'b0, bfly_q} == pairs_m1);
	assign emit_last = ({1'b0, idx_q} == len_m1);
	assign out_free  = !out_valid_q || out_ready;

	assign in_ready    = (state_q == ST_LOAD);
	assign out_valid   = out_valid_q;
	assign coefficient = coef_q;
	assign last_out    = last_q;

	// store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_ra    = '0;
		mem_rb    = '0;
		unique case (state_q)
			ST_LOAD: begin
				mem_we    = in_valid;
				mem_waddr = cnt_q;
				mem_wdata = COEF_W'(sample);
			end
			ST_RD: begin
				// previous pair's difference goes out while this pair is read
				mem_re    = 1'b1;
				mem_ra    = addr_a;
				mem_rb    = addr_b;
				mem_we    = pend_q;
				mem_waddr = pend_addr_q;
				mem_wdata = diff_q;
			end
			ST_WS: begin
				mem_we    = 1'b1;
				mem_waddr = addr_a;
				mem_wdata = rd_a_q + rd_b_q;
			end
			ST_WD: begin
				mem_we    = 1'b1;
				mem_waddr = pend_addr_q;
				mem_wdata = diff_q;
			end
			ST_EMIT_RD: begin
				mem_re = 1'b1;
				mem_ra = idx_q;
			end
			ST_EMIT: begin
				// prefetch the next word as the current one is registered
				mem_re = out_free && !emit_last;
				mem_ra = idx_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_a_q <= store_q[mem_ra];
			rd_b_q <= store_q[mem_rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cfg_q       <= CFG_RESET;
			cnt_q       <= '0;
			len_log_q   <= '0;
			stage_q     <= '0;
			bfly_q      <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			pend_addr_q <= '0;
			diff_q      <= '0;
			out_valid_q <= 1'b0;
			coef_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			// in ST_EMIT the emit branch below owns out_valid_q
			if (out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (load_next >= len_in) begin
							cnt_q     <= '0;
							len_log_q <= eff_log;
							stage_q   <= '0;
							bfly_q    <= '0;
							idx_q     <= '0;
							pend_q    <= 1'b0;
							state_q   <= (eff_log == '0) ? ST_EMIT_RD : ST_RD;
						end else begin
							cnt_q <= load_next[AW-1:0];
						end
					end
				end
				ST_RD: begin
					pend_q  <= 1'b0;
					state_q <= ST_WS;
				end
				ST_WS: begin
					diff_q      <= rd_a_q - rd_b_q;
					pend_addr_q <= addr_b;
					pend_q      <= 1'b1;
					if (bfly_last) begin
						state_q <= ST_WD;
					end else begin
						bfly_q  <= bfly_q + AW'(1);
						state_q <= ST_RD;
					end
				end
				ST_WD: begin
					// drain the last difference before the next pass or the emit walk reads
					pend_q <= 1'b0;
					bfly_q <= '0;
					if (stage_q + CFG_W'(1) == len_log_q) begin
						idx_q   <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						stage_q <= stage_q + CFG_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						coef_q      <= rd_a_q;
						last_q      <= emit_last;
						if (emit_last) begin
							state_q <= ST_LOAD;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

FILE: sv/wht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wht_checker
// Port-level checks of the Walsh-Hadamard transform unit, bound to the top.
// ----------------------------------------------------------------------------
`include "walsh_hadamard_transform_unit_assert.svh"

module wht_checker #(
	parameter int COEF_W = 23
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [COEF_W-1:0] coefficient,
	input logic                     last_out
);

	// a stalled word holds
	`WHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coefficient) && $stable(last_out))

	// within a vector the emit walk runs without bubbles
	`WHT_ASSERT_NEXT(a_emit_no_gap, out_valid && out_ready && !last_out, out_valid)

	// loading never overlaps an unfinished emit walk
	`WHT_ASSERT_NOW(a_load_after_emit, in_ready && out_valid, last_out)

endmodule

bind walsh_hadamard_transform_unit wht_checker #(.COEF_W(COEF_W)) u_wht_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.coefficient (coefficient),
	.last_out    (last_out)
);

FILE: bench/walsh_hadamard_transform_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walsh_hadamard_transform_unit_tb
// Self-checking bench for the integer Walsh-Hadamard transform unit.
// ----------------------------------------------------------------------------
// Samples are pushed through the valid/ready input with random gaps. A
// scoreboard class keeps its own copy of the vector store, load count and
// length register, runs the butterfly stages whenever a vector completes and
// queues the coefficients in index order. Each coefficient word taken from
// the output is compared against the head of that queue. A directed opening
// covers the sample extremes, length one and two, a length cut and a length
// change with a partly loaded vector. Random phases then sweep every
// register value, including the saturating one.
// ----------------------------------------------------------------------------
module walsh_hadamard_transform_unit_tb;
	import wht_pkg::*;

	localparam int LOG_CAP      = $clog2(DEF_MAX_LENGTH + 1) - 1;
	localparam int COEF_W       = DEF_SAMPLE_WIDTH + LOG_CAP + 1;
	localparam int STORE_DEPTH  = DEF_MAX_LENGTH;
	localparam int RANDOM_ITEMS = 370;
	localparam int LONG_HOLD    = 1000;
	localparam int SETTLE       = 8;
	localparam int DRAIN        = 600;

	typedef logic signed [DEF_SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]           coef_t;
	typedef struct packed {
		coef_t value;
		logic  last;
	} coef_word_t;

	typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_ALTERNATE, FILL_SMALL} fill_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(DEF_SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(DEF_SAMPLE_WIDTH-1){1'b0}}};

	class wht_scoreboard;
		logic [CFG_W-1:0] log2_len;
		int               vec_store[STORE_DEPTH];
		int               loaded;
		coef_word_t       pending_coefs[$];
		int               errors;

		function new();
			log2_len = CFG_RESET;
			loaded   = 0;
			errors   = 0;
		endfunction

		function void set_log2_length(logic [CFG_W-1:0] k);
			log2_len = k;
		endfunction

		// length saturates at the largest power of two within MAX_LENGTH
		function int vector_length();
			int n;
			int cap;
			n   = 1 << log2_len;
			cap = 1;
			while (cap * 2 <= DEF_MAX_LENGTH)
				cap = cap * 2;
			return (n > cap) ? cap : n;
		endfunction

		function void take_sample(sample_t s);
			int         n;
			int         half;
			int         i;
			int         j;
			int         u;
			int         v;
			int         work[STORE_DEPTH];
			coef_word_t w;
			n = vector_length();
			if (loaded >= STORE_DEPTH)
				loaded = 0;
			vec_store[loaded] = int'(s);
			loaded++;
			if (loaded < n)
				return;
			for (i = 0; i < n; i++)
				work[i] = vec_store[i];
			for (half = 1; half < n; half = half * 2) begin
				for (i = 0; i < n; i += 2 * half) begin
					for (j = 0; j < half; j++) begin
						u = work[i + j];
						v = work[i + j + half];
						work[i + j]        = u + v;
						work[i + j + half] = u - v;
					end
				end
			end
			for (i = 0; i < n; i++) begin
				w.value = coef_t'(work[i]);
				w.last  = (i == n - 1);
				pending_coefs.push_back(w);
			end
			loaded = 0;
		endfunction

		function void compare_coefficient(coef_t value, logic last);
			coef_word_t want;
			if (pending_coefs.size() == 0) begin
				$error("coefficient: none expected, got %0d (last_out %0b)", value, last);
				errors++;
				return;
			end
			want = pending_coefs.pop_front();
			if (value !== want.value) begin
				$error("coefficient: expected %0d, got %0d", want.value, value);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_out: expected %0b, got %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	sample_t          sample    = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	coef_t            coefficient;
	logic             last_out;

	wht_scoreboard coef_sb;
	bit            long_hold_armed = 1'b0;

	walsh_hadamard_transform_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.coefficient (coefficient),
		.last_out    (last_out)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic sample_t make_sample(fill_t fill, int idx);
		case (fill)
			FILL_MAX:       return SAMPLE_MAX;
			FILL_MIN:       return SAMPLE_MIN;
			FILL_ALTERNATE: return (idx % 2) ? SAMPLE_MIN : SAMPLE_MAX;
			FILL_SMALL:     return sample_t'($urandom_range(0, 6) - 3);
			default:        return sample_t'($urandom);
		endcase
	endfunction

	// valid is left high on return; the caller either sends again or drops it
	task automatic send_sample(input sample_t s, input bit no_gaps);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		coef_sb.take_sample(s);
	endtask

	task automatic write_log2_length(input logic [CFG_W-1:0] k);
		while (coef_sb.pending_coefs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		coef_sb.set_log2_length(k);
	endtask

	task automatic send_random_items(input int count, input bit no_gaps);
		int    i;
		int    vlen;
		fill_t fill;
		vlen = coef_sb.vector_length();
		fill = FILL_RANDOM;
		for (i = 0; i < count; i++) begin
			if (i % vlen == 0)
				fill = ($urandom_range(0, 9) < 5) ? FILL_RANDOM
					: fill_t'($urandom_range(FILL_MAX, FILL_SMALL));
			send_sample(make_sample(fill, i), no_gaps);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		int plan[8];
		int phase;
		int sent;
		int vlen;
		int count;
		plan    = '{7, 0, 3, 6, 1, 5, 2, 4};
		coef_sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length one: every sample comes straight back
		write_log2_length(3'd0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(sample_t'(0), 1'b0);
		send_sample(sample_t'(-1), 1'b0);
		in_valid <= 1'b0;

		write_log2_length(3'd1);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		send_sample(SAMPLE_MIN, 1'b1);
		in_valid <= 1'b0;

		// length cut below the load count: next word closes the vector
		write_log2_length(3'd2);
		send_sample(sample_t'(1), 1'b0);
		send_sample(sample_t'(-1), 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		in_valid <= 1'b0;
		write_log2_length(3'd1);
		send_sample(SAMPLE_MIN, 1'b0);
		in_valid <= 1'b0;

		// register write keeps the partly loaded vector
		write_log2_length(3'd3);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(sample_t'(5), 1'b0);
		in_valid <= 1'b0;
		write_log2_length(3'd2);
		send_sample(sample_t'(-7), 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		in_valid <= 1'b0;

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			write_log2_length(CFG_W'((phase < 8) ? plan[phase] : $urandom_range(0, 7)));
			if (phase == 0)
				long_hold_armed = 1'b1;
			vlen  = coef_sb.vector_length();
			count = ((vlen >= 32) ? 1 : $urandom_range(1, 4)) * vlen;
			// leave a partial vector for the next length now and then; during
			// the long hold-off this keeps the sender offering into a full unit
			if (vlen > 1 && (phase == 0 || $urandom_range(0, 3) == 0))
				count += $urandom_range(1, vlen - 1);
			send_random_items(count, $urandom_range(0, 3) == 0);
			sent += count;
			phase++;
		end

		while (coef_sb.pending_coefs.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (coef_sb.errors == 0)
			$display("walsh_hadamard_transform_unit regression: pass");
		else
			$display("walsh_hadamard_transform_unit regression: fail");
		$finish;
	end

	// output side: random stalls, bursts without stalls, one long hold-off
	initial begin
		int gap;
		bit rx_burst;
		rx_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 49) == 0)
				rx_burst = !rx_burst;
			gap = rx_burst ? 0 : pick_gap();
			if (long_hold_armed) begin
				long_hold_armed = 1'b0;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			coef_sb.compare_coefficient(coefficient, last_out);
		end
	end

	initial begin
		#5_000_000;
		$display("walsh_hadamard_transform_unit regression: fail");
		$finish;
	end

endmodule
